[src/pfc_pkg.sv]
// Package for the Playfair digram cipher block.
// Holds letter codes, square geometry, register indexes and small helper functions.
// No dependencies.
package pfc_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned PlaceW   = 5;
  localparam int unsigned Side     = 5;
  localparam int unsigned Cells    = 25;
  localparam int unsigned Alphabet = 26;
  localparam int unsigned KeyRegs  = 5;
  localparam int unsigned KeyW     = 45;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutDepth = 8;

  localparam logic [LetterW-1:0] LetterX = 5'd23;
  localparam logic [LetterW-1:0] LetterJ = 5'd9;
  localparam logic [2:0]         ShiftFwd  = 3'd1;
  localparam logic [2:0]         ShiftBack = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DECRYPT_MODE = 3'd0,
    REG_KEY_LENGTH   = 3'd1,
    REG_KEY_FIRST    = 3'd2,
    REG_KEY_MIDDLE   = 3'd3,
    REG_KEY_LAST     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
    logic               absent;
    logic               last;
  } pair_out_t;

  // Row of a cell index 0..24.
  function automatic logic [2:0] row_of(input logic [PlaceW-1:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // Column, given the cell index and its row.
  function automatic logic [2:0] col_of(input logic [PlaceW-1:0] p, input logic [2:0] r);
    logic [PlaceW-1:0] base;
    logic [PlaceW-1:0] diff;
    base = PlaceW'(r * 3'd5);
    diff = p - base;
    return diff[2:0];
  endfunction

  // (x + s) mod 5 for x below 5 and s below 5.
  function automatic logic [2:0] wrap5(input logic [2:0] x, input logic [2:0] s);
    logic [3:0] t;
    t = {1'b0, x} + {1'b0, s};
    if (t >= 4'd5) t = t - 4'd5;
    return t[2:0];
  endfunction

  function automatic logic [PlaceW-1:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return PlaceW'(r * 3'd5) + PlaceW'(c);
  endfunction

endpackage

[src/playfair_digram_cipher_top.sv]
// Top level of the Playfair digram cipher block.
// Depends on pfc_pkg; holds the key square memories, the build sequencer and the pair pipeline.
//
// The block keeps the 5x5 key square in two small synchronous memories: one maps a cell to its
// letter and one maps a letter to its cell. After reset, and after every write to a register,
// a build sequencer refills the square, one letter a cycle (the key letters first, then the
// alphabet, each phase closed by a step that writes nothing); s_axis_tready stays low meanwhile.
// In normal use a letter is taken every cycle, while the output queue has room, when it releases
// at most one pair; a doubled letter at message end releases two pairs and holds input off while
// the second pair issues, since the pipeline issues one pair per cycle. A pair passes from
// acceptance to the output queue through the letter-to-cell read, the cell-to-letter read and
// the queue write of the formed result. An eight-entry output queue decouples the result side,
// and input is accepted only while the queue has room for all pairs in flight.
module playfair_digram_cipher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pfc_pkg::KeyW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [4:0] plain_letter
  input  logic                        s_axis_tlast,  // message_end
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [4:0] first_out, [9:5] second_out
  output logic                        m_axis_tuser,  // not_in_square
  output logic                        m_axis_tlast   // final_pair
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_KEY  = 3'b010,
    ST_FILL = 3'b100
  } build_e;

  localparam int unsigned CntW = $clog2(OutDepth + 1);
  localparam int unsigned PtrW = $clog2(OutDepth);

  // Configuration registers.
  logic             decrypt_q;
  logic [4:0]       key_len_q;
  logic [44:0]      key_first_q;
  logic [39:0]      key_middle_q;
  logic [39:0]      key_last_q;
  logic [124:0]     key_all;
  logic             rebuild;

  assign rebuild = cfg_we_i && (cfg_idx_i <= REG_KEY_LAST);
  assign key_all = {key_last_q, key_middle_q, key_first_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q    <= 1'b0;
      key_len_q    <= '0;
      key_first_q  <= '0;
      key_middle_q <= '0;
      key_last_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DECRYPT_MODE: decrypt_q    <= cfg_data_i[0];
        REG_KEY_LENGTH:   key_len_q    <= cfg_data_i[4:0];
        REG_KEY_FIRST:    key_first_q  <= cfg_data_i;
        REG_KEY_MIDDLE:   key_middle_q <= cfg_data_i[39:0];
        REG_KEY_LAST:     key_last_q   <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  // Square memories; a letter whose used bit is clear reads as absent.
  logic [LetterW-1:0] sq_mem [Cells];
  logic [PlaceW-1:0]  lp_mem [Alphabet];
  logic [Alphabet-1:0] used_q, used_d;

  build_e             st_q, st_d;
  logic [4:0]         bidx_q, bidx_d;
  logic [4:0]         bcnt_q, bcnt_d;
  logic [4:0]         key_len_sat;
  logic [LetterW-1:0] key_c;
  logic               wr_en;
  logic [LetterW-1:0] wr_letter;

  assign key_len_sat = (key_len_q > 5'd25) ? 5'd25 : key_len_q;
  assign key_c       = key_all[bidx_q * 5 +: 5];

  always_comb begin
    st_d      = st_q;
    bidx_d    = bidx_q;
    bcnt_d    = bcnt_q;
    used_d    = used_q;
    wr_en     = 1'b0;
    wr_letter = key_c;
    case (st_q)
      ST_KEY: begin
        if (bidx_q < key_len_sat) begin
          if ((key_c < 5'd26) && !used_q[key_c] && (bcnt_q < 5'd25)) begin
            wr_en = 1'b1;
          end
          bidx_d = bidx_q + 5'd1;
        end else begin
          st_d   = ST_FILL;
          bidx_d = '0;
        end
      end
      ST_FILL: begin
        wr_letter = bidx_q;
        if ((bidx_q < 5'd26) && (bcnt_q < 5'd25)) begin
          if ((bidx_q != LetterJ) && !used_q[bidx_q]) begin
            wr_en = 1'b1;
          end
          bidx_d = bidx_q + 5'd1;
        end else begin
          st_d = ST_IDLE;
        end
      end
      default: ;
    endcase
    if (wr_en) begin
      used_d[wr_letter] = 1'b1;
      bcnt_d            = bcnt_q + 5'd1;
    end
    if (rebuild) begin
      st_d   = ST_KEY;
      bidx_d = '0;
      bcnt_d = '0;
      used_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_KEY;
      bidx_q <= '0;
      bcnt_q <= '0;
      used_q <= '0;
    end else begin
      st_q   <= st_d;
      bidx_q <= bidx_d;
      bcnt_q <= bcnt_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sq_mem[bcnt_q]    <= wr_letter;
      lp_mem[wr_letter] <= bcnt_q;
    end
  end

  // Pairing of incoming letters.
  logic               held_valid_q, held_valid_d;
  logic [LetterW-1:0] held_q, held_d;
  logic               pend_valid_q, pend_valid_d;
  logic [LetterW-1:0] pend_a_q, pend_a_d;
  logic               in_fire;
  logic               iss_valid;
  logic [LetterW-1:0] iss_a, iss_b;
  logic               iss_last;
  logic [LetterW-1:0] in_letter;
  logic [CntW-1:0]    oq_cnt_q;
  logic               s1_valid_q, s2_valid_q;
  logic [CntW:0]      in_flight;

  assign in_letter = s_axis_tdata[4:0];
  assign in_flight = {1'b0, oq_cnt_q} + (CntW+1)'(s1_valid_q) + (CntW+1)'(s2_valid_q)
                   + (CntW+1)'(pend_valid_q);
  assign s_axis_tready = (st_q == ST_IDLE) && !pend_valid_q
                       && (in_flight <= (CntW+1)'(OutDepth - 2));
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    held_valid_d = held_valid_q;
    held_d       = held_q;
    pend_valid_d = 1'b0;
    pend_a_d     = pend_a_q;
    iss_valid    = 1'b0;
    iss_a        = held_q;
    iss_b        = LetterX;
    iss_last     = 1'b0;
    if (pend_valid_q) begin
      iss_valid = 1'b1;
      iss_a     = pend_a_q;
      iss_last  = 1'b1;
    end else if (in_fire) begin
      if (held_valid_q) begin
        iss_valid = 1'b1;
        if (in_letter == held_q) begin
          if (s_axis_tlast) begin
            pend_valid_d = 1'b1;
            pend_a_d     = in_letter;
            held_valid_d = 1'b0;
          end else begin
            held_d = in_letter;
          end
        end else begin
          iss_b        = in_letter;
          iss_last     = s_axis_tlast;
          held_valid_d = 1'b0;
          held_d       = '0;
        end
      end else if (s_axis_tlast) begin
        iss_valid = 1'b1;
        iss_a     = in_letter;
        iss_last  = 1'b1;
      end else begin
        held_valid_d = 1'b1;
        held_d       = in_letter;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_a_q <= pend_a_d;
  end

  // Stage 1: letter-to-cell reads.
  logic [LetterW-1:0] s1_a_q, s1_b_q;
  logic               s1_last_q, s1_abs_q;
  logic [PlaceW-1:0]  pa_q, pb_q;
  logic               abs_a, abs_b;

  assign abs_a = (iss_a >= 5'd26) || !used_q[iss_a];
  assign abs_b = (iss_b >= 5'd26) || !used_q[iss_b];

  always_ff @(posedge clk_i) begin
    s1_a_q    <= iss_a;
    s1_b_q    <= iss_b;
    s1_last_q <= iss_last;
    s1_abs_q  <= abs_a || abs_b;
    pa_q      <= lp_mem[(iss_a < 5'd26) ? iss_a : 5'd0];
    pb_q      <= lp_mem[(iss_b < 5'd26) ? iss_b : 5'd0];
  end

  // Stage 2: cipher rules and cell-to-letter reads.
  logic [2:0]        ra, ca, rb, cb, sh;
  logic [PlaceW-1:0] na, nb;
  logic [LetterW-1:0] s2_a_q, s2_b_q, qa_q, qb_q;
  logic               s2_last_q, s2_abs_q;

  always_comb begin
    sh = decrypt_q ? ShiftBack : ShiftFwd;
    ra = row_of(pa_q);
    rb = row_of(pb_q);
    ca = col_of(pa_q, ra);
    cb = col_of(pb_q, rb);
    if (ra == rb) begin
      na = cell_of(ra, wrap5(ca, sh));
      nb = cell_of(rb, wrap5(cb, sh));
    end else if (ca == cb) begin
      na = cell_of(wrap5(ra, sh), ca);
      nb = cell_of(wrap5(rb, sh), cb);
    end else begin
      na = cell_of(ra, cb);
      nb = cell_of(rb, ca);
    end
    if (s1_abs_q) begin
      na = '0;
      nb = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_a_q    <= s1_a_q;
    s2_b_q    <= s1_b_q;
    s2_last_q <= s1_last_q;
    s2_abs_q  <= s1_abs_q;
    qa_q      <= sq_mem[na];
    qb_q      <= sq_mem[nb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= iss_valid;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Output queue.
  pair_out_t          oq_mem [OutDepth];
  logic [PtrW-1:0]    oq_wp_q, oq_rp_q;
  pair_out_t          s3_res;
  logic               oq_pop;

  always_comb begin
    s3_res.last = s2_last_q;
    if (s2_abs_q) begin
      s3_res.first  = s2_a_q;
      s3_res.second = s2_b_q;
      s3_res.absent = 1'b1;
    end else begin
      s3_res.first  = qa_q;
      s3_res.second = qb_q;
      s3_res.absent = 1'b0;
    end
  end

  assign m_axis_tvalid = (oq_cnt_q != '0);
  assign oq_pop        = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      oq_mem[oq_wp_q] <= s3_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wp_q  <= '0;
      oq_rp_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (s2_valid_q) oq_wp_q <= oq_wp_q + PtrW'(1);
      if (oq_pop)     oq_rp_q <= oq_rp_q + PtrW'(1);
      oq_cnt_q <= oq_cnt_q + CntW'(s2_valid_q) - CntW'(oq_pop);
    end
  end

  assign m_axis_tdata = {6'd0, oq_mem[oq_rp_q].second, oq_mem[oq_rp_q].first};
  assign m_axis_tuser = oq_mem[oq_rp_q].absent;
  assign m_axis_tlast = oq_mem[oq_rp_q].last;

  // The credit check must keep the queue from overflowing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_cnt_q <= CntW'(OutDepth))
    else $error("output queue overflow");

  // No item is taken while the square is being rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready)
    else $error("item accepted during square build");

  // A second pending pair only follows a closed message, so nothing is held then.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> !held_valid_q)
    else $error("pending pair with a held letter");

  // A pending pair always issues in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |=> s2_valid_q || s1_valid_q)
    else $error("pending pair lost");

endmodule

[tb/sv/playfair_digram_cipher_top_test.sv]
// Testbench for the Playfair digram cipher block: streams letters and checks every pair.
// Depends on pfc_pkg and playfair_digram_cipher_top; predicts the key square and pairing itself.
`timescale 1ns / 1ps

class pair_scoreboard;
  bit          decrypt;
  logic [4:0]  key_len;
  logic [44:0] key_first;
  logic [39:0] key_middle;
  logic [39:0] key_last;
  logic [4:0]  cell_letter[25];
  logic [5:0]  letter_cell[26];
  logic [4:0]  held;
  bit          held_ok;
  pfc_pkg::pair_out_t pending_pairs[$];
  int          errors;

  function new();
    decrypt = 0; key_len = 0; key_first = 0; key_middle = 0; key_last = 0;
    held = 0; held_ok = 0; errors = 0;
    rebuild();
  endfunction

  function logic [4:0] key_at(int i);
    if (i < 9) return key_first[5*i +: 5];
    if (i < 17) return key_middle[5*(i-9) +: 5];
    return key_last[5*(i-17) +: 5];
  endfunction

  function void rebuild();
    int n;
    int len;
    logic [4:0] c;
    n = 0;
    len = (key_len > 25) ? 25 : key_len;
    foreach (cell_letter[i]) cell_letter[i] = 0;
    foreach (letter_cell[i]) letter_cell[i] = 6'h20;
    for (int i = 0; i < len; i++) begin
      c = key_at(i);
      if (c < 26 && letter_cell[c] == 6'h20 && n < 25) begin
        cell_letter[n] = c; letter_cell[c] = n; n++;
      end
    end
    for (int i = 0; i < 26 && n < 25; i++) begin
      if (i != pfc_pkg::LetterJ && letter_cell[i] == 6'h20) begin
        cell_letter[n] = i; letter_cell[i] = n; n++;
      end
    end
  endfunction

  function void set_reg(pfc_pkg::cfg_reg_e idx, logic [44:0] v);
    case (idx)
      pfc_pkg::REG_DECRYPT_MODE: decrypt = v[0];
      pfc_pkg::REG_KEY_LENGTH:   key_len = v[4:0];
      pfc_pkg::REG_KEY_FIRST:    key_first = v;
      pfc_pkg::REG_KEY_MIDDLE:   key_middle = v[39:0];
      pfc_pkg::REG_KEY_LAST:     key_last = v[39:0];
      default: ;
    endcase
    rebuild();
  endfunction

  function void cipher_pair(logic [4:0] a, logic [4:0] b, bit fin);
    pfc_pkg::pair_out_t r;
    int pa, pb, ra, ca, rb, cb, s, na, nb;
    pa = (a < 26) ? letter_cell[a] : 6'h20;
    pb = (b < 26) ? letter_cell[b] : 6'h20;
    s = decrypt ? 4 : 1;
    r.last = fin;
    if (pa[5] || pb[5]) begin
      r.first = a; r.second = b; r.absent = 1;
    end else begin
      ra = pa / 5; ca = pa % 5; rb = pb / 5; cb = pb % 5;
      if (ra == rb) begin
        na = ra*5 + (ca+s)%5; nb = rb*5 + (cb+s)%5;
      end else if (ca == cb) begin
        na = ((ra+s)%5)*5 + ca; nb = ((rb+s)%5)*5 + cb;
      end else begin
        na = ra*5 + cb; nb = rb*5 + ca;
      end
      r.first = cell_letter[na]; r.second = cell_letter[nb]; r.absent = 0;
    end
    pending_pairs.push_back(r);
  endfunction

  function void note_letter(logic [4:0] letter, bit fin);
    if (held_ok) begin
      if (letter == held) begin
        cipher_pair(held, pfc_pkg::LetterX, 0);
        if (fin) begin
          cipher_pair(letter, pfc_pkg::LetterX, 1);
          held_ok = 0;
        end else held = letter;
      end else begin
        cipher_pair(held, letter, fin);
        held_ok = 0; held = 0;
      end
    end else if (fin) cipher_pair(letter, pfc_pkg::LetterX, 1);
    else begin
      held = letter; held_ok = 1;
    end
  endfunction

  function void check_pair(pfc_pkg::pair_out_t got);
    pfc_pkg::pair_out_t want;
    if (pending_pairs.size() == 0) begin
      $display("%0t: unexpected pair, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_pairs.pop_front();
    if (got.first !== want.first) begin
      $display("%0t: first_out expected %0d actual %0d", $time, want.first, got.first);
      errors++;
    end
    if (got.second !== want.second) begin
      $display("%0t: second_out expected %0d actual %0d", $time, want.second, got.second);
      errors++;
    end
    if (got.absent !== want.absent) begin
      $display("%0t: not_in_square expected %0d actual %0d", $time, want.absent, got.absent);
      errors++;
    end
    if (got.last !== want.last) begin
      $display("%0t: final_pair expected %0d actual %0d", $time, want.last, got.last);
      errors++;
    end
  endfunction
endclass

module playfair_digram_cipher_top_test;
  import pfc_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = 0;
  logic [44:0] cfg_data_i = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  pair_scoreboard sb;
  int idle_cycles;
  bit stim_done;
  bit recv_on;

  playfair_digram_cipher_top dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Receiver: checks each pair and drops ready at random, but stays ready while recv_on is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_pair('{first: m_axis_tdata[4:0], second: m_axis_tdata[9:5],
                        absent: m_axis_tuser, last: m_axis_tlast});
      end
      if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      m_axis_tready <= recv_on ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) if (idle_cycles > 5000) begin
    $display("playfair_digram_cipher_top verification failed");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, logic [44:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // Waits for all pairs, then lets the pipeline and square rebuild settle.
  task automatic drain();
    while (sb.pending_pairs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic send_letter(logic [4:0] letter, bit fin);
    s_axis_tvalid <= 1; s_axis_tdata <= {3'b0, letter}; s_axis_tlast <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_letter(letter, fin);
    if ($urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [44:0] rand_keys(int w, bit valid_only);
    logic [44:0] v;
    v = 0;
    for (int i = 0; i < w / 5; i++)
      v[5*i +: 5] = valid_only ? $urandom_range(0, 25) : $urandom_range(0, 31);
    return v;
  endfunction

  task automatic random_phase(int n);
    int len;
    while (n > 0) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len && n > 0; i++, n--) begin
        int r;
        logic [4:0] l;
        r = $urandom_range(0, 19);
        if (r == 0) l = $urandom_range(26, 31);
        else if (r < 4) l = sb.held_ok ? sb.held : LetterX;
        else l = $urandom_range(0, 25);
        send_letter(l, (i == len - 1) || ($urandom_range(0, 9) == 0));
      end
      if ($urandom_range(0, 1)) begin
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    idle_sender();
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    stim_done = 0;
    recv_on = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    repeat (60) @(posedge clk_i);

    // Directed: plain square, extremes, doubles, lone letter, absent letters.
    send_letter(0, 0); send_letter(25, 0);
    send_letter(4, 0); send_letter(4, 1);
    send_letter(7, 1);
    send_letter(LetterJ, 0); send_letter(0, 0);
    send_letter(31, 0); send_letter(26, 1);
    send_letter(0, 0); send_letter(5, 0);
    send_letter(6, 0); send_letter(24, 1);
    send_letter(LetterX, 0); send_letter(LetterX, 1);
    send_letter(11, 0); send_letter(11, 0); send_letter(12, 1);
    idle_sender();
    drain();

    write_reg(REG_DECRYPT_MODE, 1);
    write_reg(REG_KEY_LENGTH, 31);
    write_reg(REG_KEY_FIRST, {45{1'b1}});
    write_reg(REG_KEY_MIDDLE, {5'd9, 35'h0});
    write_reg(REG_KEY_LAST, 40'h0);
    repeat (60) @(posedge clk_i);
    send_letter(LetterJ, 0); send_letter(25, 0); send_letter(0, 1);
    idle_sender();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DECRYPT_MODE, ph % 2);
      write_reg(REG_KEY_LENGTH, (ph == 5) ? 0 : $urandom_range(0, 31));
      write_reg(REG_KEY_FIRST, rand_keys(45, ph < 3));
      write_reg(REG_KEY_MIDDLE, rand_keys(40, ph < 3));
      write_reg(REG_KEY_LAST, rand_keys(40, ph != 1));
      repeat (60) @(posedge clk_i);
      recv_on = (ph == 2);
      random_phase(115);
      drain();
    end
    stim_done = 1;
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_pairs.size() == 0)
      $display("playfair_digram_cipher_top verification clean");
    else
      $display("playfair_digram_cipher_top verification failed");
    $finish;
  end
endmodule

[files.f]
src/pfc_pkg.sv
src/playfair_digram_cipher_top.sv
tb/sv/playfair_digram_cipher_top_test.sv
